// ===== hw/rtl/isp_pkg.sv =====
`timescale 1ns / 1ps

package isp_pkg;

  // Field widths of the item ports.
  localparam int SampleW = 16;
  localparam int SlopeW  = 33;
  localparam int AvgW    = 32;
  localparam int SpreadW = 48;
  localparam int PosW    = 13;

  // Configuration port.
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 13;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LEN   = 2'd0,
    CFG_CNT   = 2'd1,
    CFG_START = 2'd2
  } cfg_idx_e;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_ACC,
    OP_SLP1,
    OP_SLP2,
    OP_SLP3,
    OP_DIV_SLP,
    OP_DIV_MEAN,
    OP_DIV_VAR,
    OP_VAR1,
    OP_VAR2,
    OP_EMIT
  } op_e;

  typedef struct packed {
    op_e  op;
    logic tot;   // work on the whole-subsequence sums
  } cmd_t;

  typedef struct packed {
    logic iv_close;   // the next sample closes an interval
    logic sum_close;  // the next sample also closes the subsequence
    logic div_busy;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/isp_ctrl.sv =====
`timescale 1ns / 1ps

module isp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  isp_pkg::sts_t sts_i,
  output isp_pkg::cmd_t cmd_o
);
  import isp_pkg::*;

  typedef enum logic [3:0] {
    ST_RUN, ST_SLP1, ST_SLP2, ST_SLP3, ST_DSLP, ST_WSLP, ST_DMEAN, ST_WMEAN,
    ST_VAR1, ST_VAR2, ST_DVAR, ST_WVAR, ST_EMIT
  } ctl_e;

  ctl_e state_q;
  logic tot_q;
  logic sum_pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_RUN;
      tot_q      <= 1'b0;
      sum_pend_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_RUN: begin
          if (in_valid_i && sts_i.iv_close) begin
            sum_pend_q <= sts_i.sum_close;
            tot_q      <= 1'b0;
            state_q    <= ST_SLP1;
          end
        end
        ST_SLP1: state_q <= ST_SLP2;
        ST_SLP2: state_q <= ST_SLP3;
        ST_SLP3: state_q <= ST_DSLP;
        ST_DSLP: state_q <= ST_WSLP;
        ST_WSLP: begin
          if (!sts_i.div_busy) state_q <= ST_DMEAN;
        end
        ST_DMEAN: state_q <= ST_WMEAN;
        ST_WMEAN: begin
          if (!sts_i.div_busy) state_q <= ST_VAR1;
        end
        ST_VAR1: state_q <= ST_VAR2;
        ST_VAR2: state_q <= ST_DVAR;
        ST_DVAR: state_q <= ST_WVAR;
        ST_WVAR: begin
          if (!sts_i.div_busy) state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (sts_i.out_free) begin
            if (!tot_q && sum_pend_q) begin
              tot_q   <= 1'b1;
              state_q <= ST_DMEAN;
            end else begin
              tot_q   <= 1'b0;
              state_q <= ST_RUN;
            end
          end
        end
        default: state_q <= ST_RUN;
      endcase
    end
  end

  assign in_stall_o = (state_q != ST_RUN);

  always_comb begin
    cmd_o.tot = tot_q;
    unique case (state_q)
      ST_RUN:   cmd_o.op = in_valid_i ? OP_ACC : OP_IDLE;
      ST_SLP1:  cmd_o.op = OP_SLP1;
      ST_SLP2:  cmd_o.op = OP_SLP2;
      ST_SLP3:  cmd_o.op = OP_SLP3;
      ST_DSLP:  cmd_o.op = OP_DIV_SLP;
      ST_DMEAN: cmd_o.op = OP_DIV_MEAN;
      ST_VAR1:  cmd_o.op = OP_VAR1;
      ST_VAR2:  cmd_o.op = OP_VAR2;
      ST_DVAR:  cmd_o.op = OP_DIV_VAR;
      ST_EMIT:  cmd_o.op = sts_i.out_free ? OP_EMIT : OP_IDLE;
      default:  cmd_o.op = OP_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/isp_dpath.sv =====
`timescale 1ns / 1ps

module isp_dpath #(
  parameter int MAX_SUB_LEN = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [isp_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [isp_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic signed [isp_pkg::SampleW-1:0] sample_i,
  input  isp_pkg::cmd_t                     cmd_i,
  output isp_pkg::sts_t                     sts_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              kind_o,
  output logic signed [isp_pkg::SlopeW-1:0] slope_o,
  output logic signed [isp_pkg::AvgW-1:0]   average_o,
  output logic [isp_pkg::SpreadW-1:0]       spread_o,
  output logic [isp_pkg::PosW-1:0]          first_position_o,
  output logic [isp_pkg::PosW-1:0]          last_position_o,
  output logic                              last_o
);
  import isp_pkg::*;

  localparam int LenCap   = (MAX_SUB_LEN < 4096) ? MAX_SUB_LEN : 4096;
  localparam int DivSteps = 80;

  // Configuration.
  logic [12:0] len_q, cnt_q;
  logic [11:0] start_q;

  // Counters and running sums.
  logic [11:0]        idx_q;
  logic [16:0]        inum_q;
  logic [16:0]        tot_n_q;
  logic signed [28:0] isum_q;
  logic [42:0]        isq_q;
  logic signed [39:0] iw_q;
  logic signed [32:0] tsum_q;
  logic [46:0]        tsq_q;

  // Snapshots taken when an interval or the subsequence closes.
  logic [12:0]        sn_n_q;
  logic signed [28:0] sn_s_q;
  logic [42:0]        sn_q_q;
  logic signed [39:0] sn_w_q;
  logic [16:0]        st_n_q;
  logic signed [32:0] st_s_q;
  logic [46:0]        st_q_q;

  // Work registers.
  logic signed [42:0] m1_q;
  logic [25:0]        nn_q;
  logic signed [47:0] num_q;
  logic [36:0]        den_q;
  logic [63:0]        nq_q, ss_q;
  logic [36:0]        vden_q;

  // Shift-subtract divider.
  logic [79:0] dvd_q;
  logic [36:0] rem_q, dden_q;
  logic [47:0] quo_q;
  logic [6:0]  dcnt_q;
  logic        dbusy_q, dneg_q;
  op_e         dsel_q;

  logic signed [SlopeW-1:0] slope_r_q;
  logic [SpreadW-1:0]       avg_r_q;
  logic [SpreadW-1:0]       sprd_r_q;

  // Close detection, from the stored counters only.
  logic [12:0] len_use, cnt_lo, n_new;
  logic [16:0] inum_new;
  logic [17:0] tot_new;
  logic [31:0] cnt_prod;
  logic        cap_hit, cnt_hit, iv_close, sum_close;

  always_comb begin
    if (len_q < 13'd2) begin
      len_use = 13'd2;
    end else if (len_q > 13'(LenCap)) begin
      len_use = 13'(LenCap);
    end else begin
      len_use = len_q;
    end
    cnt_lo    = (cnt_q == 13'd0) ? 13'd1 : cnt_q;
    n_new     = {1'b0, idx_q} + 13'd1;
    inum_new  = inum_q + 17'd1;
    tot_new   = {1'b0, tot_n_q} + 18'd1;
    cap_hit   = tot_new >= 18'(MAX_SUB_LEN);
    // The clamp of the count to MAX_SUB_LEN / length is met once
    // (intervals + 1) * length exceeds MAX_SUB_LEN.
    cnt_prod  = 32'(inum_new) * 32'(len_use) + 32'(len_use);
    cnt_hit   = cnt_prod > 32'(MAX_SUB_LEN);
    iv_close  = (n_new >= len_use) || cap_hit;
    sum_close = iv_close && ((inum_new >= 17'(cnt_lo)) || cnt_hit || cap_hit);
  end

  // Accumulation terms.
  logic signed [31:0] xx;
  logic signed [28:0] wx;
  logic signed [28:0] isum_nx;
  logic [42:0]        isq_nx;
  logic signed [39:0] iw_nx;
  logic signed [32:0] tsum_nx;
  logic [46:0]        tsq_nx;

  always_comb begin
    xx      = sample_i * sample_i;
    wx      = $signed({1'b0, idx_q}) * sample_i;
    isum_nx = isum_q + 29'(sample_i);
    isq_nx  = isq_q + 43'($unsigned(xx));
    iw_nx   = iw_q + 40'(wx);
    tsum_nx = tsum_q + 33'(sample_i);
    tsq_nx  = tsq_q + 47'($unsigned(xx));
  end

  // Operand selection between interval and whole-subsequence snapshots.
  logic [16:0]        n_sel;
  logic signed [32:0] s_sel;
  logic [46:0]        q_sel;
  logic signed [32:0] s_neg;
  logic [31:0]        smag;
  logic signed [47:0] num_neg;

  always_comb begin
    n_sel   = cmd_i.tot ? st_n_q : 17'(sn_n_q);
    s_sel   = cmd_i.tot ? st_s_q : 33'(sn_s_q);
    q_sel   = cmd_i.tot ? st_q_q : 47'(sn_q_q);
    s_neg   = -s_sel;
    smag    = s_sel[32] ? s_neg[31:0] : s_sel[31:0];
    num_neg = -num_q;
  end

  // Divider start operands.
  logic [63:0] st_mag;
  logic [36:0] st_den;
  logic        st_neg;

  always_comb begin
    st_mag = '0;
    st_den = 37'd1;
    st_neg = 1'b0;
    case (cmd_i.op)
      OP_DIV_SLP: begin
        if (den_q != 37'd0) begin
          st_mag = 64'($unsigned(num_q[47] ? num_neg : num_q));
          st_den = den_q;
          st_neg = num_q[47];
        end
      end
      OP_DIV_MEAN: begin
        st_mag = 64'(smag);
        st_den = 37'(n_sel);
        st_neg = s_sel[32];
      end
      OP_DIV_VAR: begin
        if (n_sel >= 17'd2 && nq_q >= ss_q) begin
          st_mag = nq_q - ss_q;
          st_den = vden_q;
        end
      end
      default: ;
    endcase
  end

  // One restoring step a cycle.
  logic [37:0] rem_sh;
  logic        ge;
  logic [36:0] rem_nx;
  logic [47:0] quo_nx, quo_neg, quo_fin;

  always_comb begin
    rem_sh  = {rem_q, dvd_q[79]};
    ge      = rem_sh >= {1'b0, dden_q};
    rem_nx  = ge ? 37'(rem_sh - {1'b0, dden_q}) : rem_sh[36:0];
    quo_nx  = {quo_q[46:0], ge};
    quo_neg = -quo_nx;
    quo_fin = dneg_q ? quo_neg : quo_nx;
  end

  logic out_free;
  assign out_free = !out_valid_o || !out_stall_i;

  // Control state, counters and sums.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= 13'd2;
      cnt_q       <= 13'd1;
      start_q     <= '0;
      idx_q       <= '0;
      inum_q      <= '0;
      tot_n_q     <= '0;
      isum_q      <= '0;
      isq_q       <= '0;
      iw_q        <= '0;
      tsum_q      <= '0;
      tsq_q       <= '0;
      dbusy_q     <= 1'b0;
      dcnt_q      <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_LEN:   len_q   <= cfg_data_i;
          CFG_CNT:   cnt_q   <= cfg_data_i;
          CFG_START: start_q <= cfg_data_i[11:0];
          default: ;
        endcase
      end
      if (cmd_i.op == OP_ACC) begin
        if (iv_close) begin
          idx_q  <= '0;
          isum_q <= '0;
          isq_q  <= '0;
          iw_q   <= '0;
          inum_q <= sum_close ? 17'd0 : inum_new;
        end else begin
          idx_q  <= idx_q + 12'd1;
          isum_q <= isum_nx;
          isq_q  <= isq_nx;
          iw_q   <= iw_nx;
        end
        if (sum_close) begin
          tot_n_q <= '0;
          tsum_q  <= '0;
          tsq_q   <= '0;
        end else begin
          tot_n_q <= tot_new[16:0];
          tsum_q  <= tsum_nx;
          tsq_q   <= tsq_nx;
        end
      end
      if (cmd_i.op == OP_DIV_SLP || cmd_i.op == OP_DIV_MEAN || cmd_i.op == OP_DIV_VAR) begin
        dbusy_q <= 1'b1;
        dcnt_q  <= '0;
      end else if (dbusy_q) begin
        dcnt_q <= dcnt_q + 7'd1;
        if (dcnt_q == 7'(DivSteps - 1)) dbusy_q <= 1'b0;
      end
      if (cmd_i.op == OP_EMIT) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op) inside
      OP_ACC: begin
        if (iv_close) begin
          sn_n_q <= n_new;
          sn_s_q <= isum_nx;
          sn_q_q <= isq_nx;
          sn_w_q <= iw_nx;
        end
        if (sum_close) begin
          st_n_q <= tot_new[16:0];
          st_s_q <= tsum_nx;
          st_q_q <= tsq_nx;
        end
      end
      OP_SLP1: m1_q <= $signed({1'b0, sn_n_q - 13'd1}) * sn_s_q;
      OP_SLP2: nn_q <= 26'(sn_n_q) * 26'(sn_n_q);
      OP_SLP3: begin
        num_q <= 48'(sn_w_q) * 48'sd12 - 48'(m1_q) * 48'sd6;
        den_q <= 37'(39'(sn_n_q) * 39'(nn_q - 26'd1));
      end
      OP_VAR1: begin
        nq_q   <= 64'(n_sel) * 64'(q_sel);
        vden_q <= 37'(34'(n_sel) * 34'(n_sel - 17'd1));
      end
      OP_VAR2: ss_q <= 64'(smag) * 64'(smag);
      OP_DIV_SLP, OP_DIV_MEAN, OP_DIV_VAR: begin
        dvd_q  <= {st_mag, 16'd0};
        rem_q  <= '0;
        quo_q  <= '0;
        dden_q <= st_den;
        dneg_q <= st_neg;
        dsel_q <= cmd_i.op;
      end
      OP_EMIT: begin
        kind_o <= cmd_i.tot;
        last_o <= cmd_i.tot;
        average_o <= avg_r_q[AvgW-1:0];
        spread_o  <= sprd_r_q;
        if (cmd_i.tot) begin
          slope_o          <= '0;
          first_position_o <= 13'(start_q) + 13'd1;
          last_position_o  <= 13'(start_q) + st_n_q[12:0];
        end else begin
          slope_o          <= slope_r_q;
          first_position_o <= '0;
          last_position_o  <= '0;
        end
      end
      default: ;
    endcase
    if (dbusy_q) begin
      dvd_q <= {dvd_q[78:0], 1'b0};
      rem_q <= rem_nx;
      quo_q <= quo_nx;
      if (dcnt_q == 7'(DivSteps - 1)) begin
        case (dsel_q)
          OP_DIV_SLP:  slope_r_q <= $signed(quo_fin[SlopeW-1:0]);
          OP_DIV_MEAN: avg_r_q   <= quo_fin;
          default:     sprd_r_q  <= quo_fin;
        endcase
      end
    end
  end

  always_comb begin
    sts_o.iv_close  = iv_close;
    sts_o.sum_close = sum_close;
    sts_o.div_busy  = dbusy_q;
    sts_o.out_free  = out_free;
  end

endmodule

// ===== hw/rtl/interval_slope_mean_variance.sv =====
`timescale 1ns / 1ps

// Interval slope, mean and variance. Samples of one subsequence arrive one
// item per cycle and each is summed as it is taken. When a sample closes
// an interval, the block stops taking items and works out the least-squares
// slope, the mean and the sample variance of that interval (16 fraction bits,
// truncated toward zero) on one shared restoring divider of 80 steps; after
// the last interval it does the same for the mean and variance of the whole
// subsequence and emits a summary item with its one-based first and last
// positions, then starts afresh. A sample that closes an interval is taken,
// then follow three multiply steps and the division for the slope, the
// division for the mean, two multiply steps and the division for the
// variance, and the emit; each division is issued, runs its 80 steps and
// hands back its result. Closing the subsequence adds two further
// divisions, two multiply steps and a second emit. Each emit waits while
// the previous result item is stalled at the output. Results leave through
// an output register, so a waiting result does not hold up the arithmetic
// until the next one is ready.
// Write the configuration registers (interval length, interval count, start
// position) only while the block is idle.
module interval_slope_mean_variance #(
  parameter int MAX_SUB_LEN = 4096
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [isp_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [isp_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [isp_pkg::SampleW-1:0] sample_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               kind_o,
  output logic signed [isp_pkg::SlopeW-1:0]  slope_o,
  output logic signed [isp_pkg::AvgW-1:0]    average_o,
  output logic [isp_pkg::SpreadW-1:0]        spread_o,
  output logic [isp_pkg::PosW-1:0]           first_position_o,
  output logic [isp_pkg::PosW-1:0]           last_position_o,
  output logic                               last_o
);
  import isp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The controller sequences accumulation, the multiply steps, the three
  // divisions per interval (two per summary) and the output register hand-over.
  isp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds the sums, snapshots, the divider and the output
  // register.
  isp_dpath #(
    .MAX_SUB_LEN (MAX_SUB_LEN)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .sample_i         (sample_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .slope_o          (slope_o),
    .average_o        (average_o),
    .spread_o         (spread_o),
    .first_position_o (first_position_o),
    .last_position_o  (last_position_o),
    .last_o           (last_o)
  );

endmodule

// ===== hw/rtl/isp_checker.sv =====
`timescale 1ns / 1ps

module isp_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               cfg_we_i,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic                               kind_o,
  input logic signed [isp_pkg::SlopeW-1:0]  slope_o,
  input logic signed [isp_pkg::AvgW-1:0]    average_o,
  input logic [isp_pkg::SpreadW-1:0]        spread_o,
  input logic [isp_pkg::PosW-1:0]           first_position_o,
  input logic [isp_pkg::PosW-1:0]           last_position_o,
  input logic                               last_o
);

  // A stalled result item holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(average_o) &&
      $stable(spread_o) && $stable(kind_o))
    else $error("result item changed while stalled");

  // Results need the divider, so none appears just after a sample is taken.
  a_no_quick_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result item appeared straight after a sample");

  // A summary item closes the subsequence and has no slope.
  a_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o |-> last_o && slope_o == '0)
    else $error("malformed summary item");

  // Interval items carry no positions.
  a_interval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !kind_o |-> !last_o && first_position_o == '0 &&
      last_position_o == '0)
    else $error("malformed interval item");

  // Configuration is only written while the block is idle.
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> !in_stall_o && !out_valid_o)
    else $error("configuration written while work was in flight");

endmodule

bind interval_slope_mean_variance isp_checker u_isp_checker (.*);

// ===== tb/interval_slope_mean_variance_tb.sv =====
`timescale 1ns / 1ps

module interval_slope_mean_variance_tb;
  import isp_pkg::*;

  localparam int MaxSubLen = 4096;
  localparam int StallLimit = 20000;

  // One result item as the block presents it.
  typedef struct packed {
    logic                      kind;
    logic [SlopeW-1:0]         slope;
    logic [AvgW-1:0]           average;
    logic [SpreadW-1:0]        spread;
    logic [PosW-1:0]           first_position;
    logic [PosW-1:0]           last_position;
    logic                      last;
  } feature_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_we_i;
  cfg_idx_e                   cfg_idx_i;
  logic [CfgDataW-1:0]        cfg_data_i;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic signed [SampleW-1:0]  sample_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic                       kind_o;
  logic signed [SlopeW-1:0]   slope_o;
  logic signed [AvgW-1:0]     average_o;
  logic [SpreadW-1:0]         spread_o;
  logic [PosW-1:0]            first_position_o;
  logic [PosW-1:0]            last_position_o;
  logic                       last_o;

  interval_slope_mean_variance #(
    .MAX_SUB_LEN(MaxSubLen)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .sample_i        (sample_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .slope_o         (slope_o),
    .average_o       (average_o),
    .spread_o        (spread_o),
    .first_position_o(first_position_o),
    .last_position_o (last_position_o),
    .last_o          (last_o)
  );

  // Expected results, oldest first, and the running tallies of the run.
  feature_t feature_q[$];
  int       mismatches;
  int       samples_sent;
  int       intervals_seen;
  int       summaries_seen;

  // Percentages of cycles in which the sender idles and the receiver stalls.
  int       send_idle_pct;
  int       recv_stall_pct;

  // The predictor's copy of the configuration and of the running sums.
  logic [12:0]     cur_len;
  logic [12:0]     cur_cnt;
  logic [11:0]     cur_start;
  longint unsigned iv_index;
  longint unsigned iv_number;
  longint          iv_sum;
  longint          iv_sq_sum;
  longint          iv_w_sum;
  longint          sub_sum;
  longint          sub_sq_sum;
  longint unsigned sub_samples;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Truncated quotient of mag over den with sixteen fraction bits.
  function automatic longint unsigned frac_quot(longint unsigned mag, longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = mag / den;
    r = mag % den;
    return (q << 16) + ((r << 16) / den);
  endfunction

  // Signed fixed-point quotient, rounded toward zero; zero for a zero divisor.
  function automatic longint unsigned signed_quot(longint num, longint unsigned den);
    longint unsigned mag;
    longint unsigned res;
    if (den == 0) return 0;
    mag = (num < 0) ? longint'(-num) : longint'(num);
    res = frac_quot(mag, den);
    return (num < 0) ? -res : res;
  endfunction

  // Sample variance from the count, the sum and the sum of squares.
  function automatic longint unsigned sample_spread(longint unsigned n, longint s, longint q);
    longint unsigned smag;
    longint unsigned nq;
    longint unsigned ss;
    smag = (s < 0) ? longint'(-s) : longint'(s);
    nq = n * longint'(q);
    ss = smag * smag;
    if (n < 2 || nq < ss) return 0;
    return frac_quot(nq - ss, n * (n - 1));
  endfunction

  // Takes one accepted sample into the predictor and queues the results it closes.
  function automatic void predict_features(logic signed [SampleW-1:0] smp);
    longint          x;
    longint          num;
    longint unsigned len;
    longint unsigned cnt;
    longint unsigned n;
    bit              cap_hit;
    feature_t        f;
    x = smp;
    len = cur_len;
    cnt = cur_cnt;
    if (len < 2) len = 2;
    if (len > MaxSubLen) len = MaxSubLen;
    if (cnt < 1) cnt = 1;
    if (cnt > MaxSubLen / len) cnt = MaxSubLen / len;

    iv_sum += x;
    iv_sq_sum += x * x;
    iv_w_sum += longint'(iv_index) * x;
    sub_sum += x;
    sub_sq_sum += x * x;
    sub_samples++;
    n = iv_index + 1;
    cap_hit = sub_samples >= MaxSubLen;
    if (n < len && !cap_hit) begin
      iv_index++;
      return;
    end

    num = 12 * iv_w_sum - 6 * longint'(n - 1) * iv_sum;
    f = '0;
    f.slope = SlopeW'(signed_quot(num, n * (n * n - 1)));
    f.average = AvgW'(signed_quot(iv_sum, n));
    f.spread = SpreadW'(sample_spread(n, iv_sum, iv_sq_sum));
    feature_q.push_back(f);
    iv_sum = 0;
    iv_sq_sum = 0;
    iv_w_sum = 0;
    iv_index = 0;
    iv_number++;

    if (iv_number >= cnt || cap_hit) begin
      f = '0;
      f.kind = 1'b1;
      f.average = AvgW'(signed_quot(sub_sum, sub_samples));
      f.spread = SpreadW'(sample_spread(sub_samples, sub_sum, sub_sq_sum));
      f.first_position = PosW'(cur_start + 13'd1);
      f.last_position = PosW'(longint'(cur_start) + sub_samples);
      f.last = 1'b1;
      feature_q.push_back(f);
      iv_number = 0;
      sub_sum = 0;
      sub_sq_sum = 0;
      sub_samples = 0;
    end
  endfunction

  // Sends one sample, idling first at random, and predicts on acceptance.
  // The valid stays high after acceptance so that it is never lowered and
  // raised again within one time step.
  task automatic send_sample(logic signed [SampleW-1:0] smp);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i <= smp;
    do @(posedge clk_i); while (in_stall_o);
    predict_features(smp);
    samples_sent++;
  endtask

  // Waits until every expected result has come, then lets the block settle.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (feature_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  // Writes all three registers back to back; only called while the block is idle.
  task automatic write_setup(logic [12:0] len, logic [12:0] cnt, logic [12:0] start);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_LEN;
    cfg_data_i <= len;
    @(posedge clk_i);
    cur_len = len;
    cfg_idx_i <= CFG_CNT;
    cfg_data_i <= cnt;
    @(posedge clk_i);
    cur_cnt = cnt;
    cfg_idx_i <= CFG_START;
    cfg_data_i <= start;
    @(posedge clk_i);
    cur_start = start[11:0];
    cfg_we_i <= 1'b0;
  endtask

  // Mostly ordinary values, with the extremes and small values mixed in.
  function automatic logic signed [SampleW-1:0] pick_sample();
    case ($urandom_range(9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($signed($urandom_range(7)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  // The reset setting: two-sample intervals, one per subsequence.
  task automatic test_reset_setting();
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    send_sample(16'sh0000);
    send_sample(-16'sd1);
    send_sample(16'sd1);
    drain_results();
  endtask

  // Lengths and counts outside their ranges are clamped by the block.
  task automatic test_clamping();
    int i;
    write_setup(13'd0, 13'd0, 13'd4095);
    for (i = 0; i < 4; i++) send_sample(pick_sample());
    drain_results();
    write_setup(13'd1, 13'd8191, 13'd4096 + 13'd7);
    for (i = 0; i < 6; i++) send_sample(pick_sample());
    drain_results();
  endtask

  // Changes taking effect inside a subsequence: an interval already past the
  // new length closes on the next sample, and a lowered count closes the
  // subsequence at the next interval end.
  task automatic test_change_midway();
    int i;
    write_setup(13'd8191, 13'd3, 13'd100);
    for (i = 0; i < 5; i++) send_sample(pick_sample());
    drain_results();
    write_setup(13'd3, 13'd3, 13'd100);
    send_sample(16'sd9);
    drain_results();
    write_setup(13'd2, 13'd5, 13'd0);
    for (i = 0; i < 4; i++) send_sample(pick_sample());
    drain_results();
    write_setup(13'd2, 13'd1, 13'd0);
    for (i = 0; i < 2; i++) send_sample(pick_sample());
    drain_results();
  endtask

  // Long intervals whose length is raised midway through the second one;
  // alternating extremes give the widest spread.
  task automatic test_long_intervals();
    int i;
    write_setup(13'd400, 13'd2, 13'd4095);
    for (i = 0; i < 500; i++) send_sample(i[0] ? 16'sh7fff : 16'sh8000);
    drain_results();
    write_setup(13'd600, 13'd1, 13'd4095);
    for (i = 500; i < 1000; i++) send_sample(i[0] ? 16'sh7fff : 16'sh8000);
    drain_results();
  endtask

  // Random subsequences with random content; most are complete, a few are
  // cut short so that the next setting takes over part-way through.
  task automatic test_random_series(int items);
    int goal;
    int len;
    int cnt;
    int total;
    int i;
    goal = samples_sent + items;
    while (samples_sent < goal) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 2) : $urandom_range(6, 2);
      cnt = $urandom_range(5, 1);
      write_setup(13'(len), 13'(cnt), 13'($urandom));
      total = len * cnt;
      if ($urandom_range(9) == 0) total = $urandom_range(total);
      for (i = 0; i < total; i++) send_sample(pick_sample());
      if ($urandom_range(4) == 0) drain_results();
      else begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (feature_q.size() != 0) @(posedge clk_i);
        repeat (50) @(posedge clk_i);
      end
    end
  endtask

  // Receiver: stalls at random and checks each accepted result in order.
  always @(posedge clk_i) begin
    feature_t got;
    feature_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = '{kind_o, slope_o, average_o, spread_o, first_position_o,
                last_position_o, last_o};
        if (feature_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result %p", $time, got);
        end else begin
          want = feature_q.pop_front();
          if (got.kind) summaries_seen++;
          else intervals_seen++;
          if (got.kind !== want.kind)
            $display("%0t: kind expected %0d got %0d", $time, want.kind, got.kind);
          if (got.slope !== want.slope)
            $display("%0t: slope expected %0h got %0h", $time, want.slope, got.slope);
          if (got.average !== want.average)
            $display("%0t: average expected %0h got %0h", $time, want.average,
                     got.average);
          if (got.spread !== want.spread)
            $display("%0t: spread expected %0h got %0h", $time, want.spread, got.spread);
          if (got.first_position !== want.first_position)
            $display("%0t: first_position expected %0d got %0d", $time,
                     want.first_position, got.first_position);
          if (got.last_position !== want.last_position)
            $display("%0t: last_position expected %0d got %0d", $time,
                     want.last_position, got.last_position);
          if (got.last !== want.last)
            $display("%0t: last expected %0d got %0d", $time, want.last, got.last);
          if (got !== want) mismatches++;
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: a long run of cycles in which nothing moves means a hang.
  always @(posedge clk_i) begin
    int quiet;
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
    else quiet++;
    if (quiet >= StallLimit) begin
      $display("%0t: no item accepted for %0d cycles", $time, StallLimit);
      $display("interval_slope_mean_variance regression: fail");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_LEN;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    sample_i = '0;
    out_stall_i = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    mismatches = 0;
    samples_sent = 0;
    intervals_seen = 0;
    summaries_seen = 0;
    cur_len = 13'd2;
    cur_cnt = 13'd1;
    cur_start = '0;
    iv_index = 0;
    iv_number = 0;
    iv_sum = 0;
    iv_sq_sum = 0;
    iv_w_sum = 0;
    sub_sum = 0;
    sub_sq_sum = 0;
    sub_samples = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_setting();
    test_clamping();
    test_change_midway();
    test_long_intervals();

    // Three idling patterns: sender mostly busy, receiver mostly stalled,
    // then sender mostly idle, receiver mostly ready, then neither holding back.
    send_idle_pct = 9;
    recv_stall_pct = 60;
    test_random_series(317);
    send_idle_pct = 60;
    recv_stall_pct = 9;
    test_random_series(317);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random_series(316);

    drain_results();
    $display("Sent %0d samples; checked %0d interval results and %0d summaries",
             samples_sent, intervals_seen, summaries_seen);
    $display("over clamped, changed-midway, long-interval and random settings.");
    if (mismatches == 0) begin
      $display("interval_slope_mean_variance regression: pass");
    end else begin
      $display("interval_slope_mean_variance regression: fail");
    end
    $finish;
  end

endmodule
